### rtl/spbc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// shortest-path budget check unit. No dependencies.

package spbc_pkg;

    // Graph sizing
    localparam int MAX_NODES   = 64;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 24;

    // Port field widths
    localparam int OP_W     = 2;
    localparam int NODE_W   = 7;
    localparam int WEIGHT_W = 16;
    localparam int BUDGET_W = 24;
    localparam int CFG_W    = 7;

    // Derived widths
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int EA_W  = 2 * IDX_W;
    localparam int SUM_W = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
    localparam int CMP_W = (DIST_BITS > BUDGET_W) ? DIST_BITS : BUDGET_W;

    // All-ones distance marks an unreachable node
    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(64);

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic ld_wr1;
        logic ld_wr2;
        logic idx_clear;
        logic init_wr;
        logic scan_clear;
        logic scan_rd;
        logic settle_wr;
        logic relax_rd;
        logic fin_rd;
        logic report;
        logic report_bad;
    } spbc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic q_ok;
        logic idx_last;
        logic found;
    } spbc_stat_t;

endpackage

### rtl/shortest_path_budget_check_unit.sv
// Top level of the shortest-path budget check unit: controller plus datapath.
// Depends on spbc_pkg, spbc_ctrl and spbc_datapath.
//
// Usage:
//   Command channel: drive op/node_a/node_b/weight/budget and raise start; the
//   transaction is taken at a rising edge with start high and busy low.
//   op load writes one edge weight both ways, op clear zeroes the whole
//   matrix, op query runs a Dijkstra search.
//   Result channel: a query gives one result, status and leftover, valid for
//   the single cycle in which done is high; the receiver cannot stall it.
//   A query's run time is set by the per-node minimum scan and row relaxation,
//   each one distance-memory read per cycle. A query with a bad start or
//   finish node reports without a search. busy is high for the whole
//   search; one item is in work at a time.
//   Configuration channel: cfg_valid/cfg_ready write node_count; cfg_ready is
//   always high and writes are taken at any time, reset value 64.
//   Reset: clears control state, then a clearing pass zeroes the edge matrix
//   with busy high; commands are taken once it ends.

module shortest_path_budget_check_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spbc_pkg::OP_W-1:0]     op,
    input  logic [spbc_pkg::NODE_W-1:0]   node_a,
    input  logic [spbc_pkg::NODE_W-1:0]   node_b,
    input  logic [spbc_pkg::WEIGHT_W-1:0] weight,
    input  logic [spbc_pkg::BUDGET_W-1:0] budget,
    output logic                          done,
    output logic                          status,
    output logic [spbc_pkg::BUDGET_W-1:0] leftover,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spbc_pkg::CFG_W-1:0]    cfg_data
);

    spbc_pkg::spbc_cmd_t  cmd;
    spbc_pkg::spbc_stat_t stat;
    logic                 busy_int;

    assign cfg_ready = 1'b1;

    spbc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy_int)
    );

    spbc_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .node_a   (node_a),
        .node_b   (node_b),
        .weight   (weight),
        .budget   (budget),
        .done     (done),
        .status   (status),
        .leftover (leftover)
    );

    assign busy = busy_int;

    // Any valid opcode taken while idle makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == spbc_pkg::OP_LOAD || op == spbc_pkg::OP_QUERY ||
                            op == spbc_pkg::OP_CLEAR)) |=> busy)
        else $error("accepted command did not raise busy");

    // Results of separate queries never land in adjacent cycles
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // A failing query reports no leftover budget
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (leftover == '0))
        else $error("leftover nonzero on failed query");

    // A result only follows the end of a search, never a fresh accept
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a running query");

endmodule

### rtl/spbc_ctrl.sv
// Sequencer for the shortest-path budget check unit: clearing pass, edge loads
// and the Dijkstra query phases. Depends on spbc_pkg.

module spbc_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [spbc_pkg::OP_W-1:0] op,
    input  spbc_pkg::spbc_stat_t     stat,
    output spbc_pkg::spbc_cmd_t      cmd,
    output logic                     busy
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CLEAR      = 4'd1;
    localparam logic [3:0] S_LOAD1      = 4'd2;
    localparam logic [3:0] S_LOAD2      = 4'd3;
    localparam logic [3:0] S_QCHECK     = 4'd4;
    localparam logic [3:0] S_INIT       = 4'd5;
    localparam logic [3:0] S_SCAN       = 4'd6;
    localparam logic [3:0] S_SCAN_END   = 4'd7;
    localparam logic [3:0] S_DECIDE     = 4'd8;
    localparam logic [3:0] S_SETTLE     = 4'd9;
    localparam logic [3:0] S_RELAX      = 4'd10;
    localparam logic [3:0] S_RELAX_END  = 4'd11;
    localparam logic [3:0] S_FINAL      = 4'd12;
    localparam logic [3:0] S_FINAL_WAIT = 4'd13;
    localparam logic [3:0] S_BAD        = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register; reset starts the matrix clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (op == spbc_pkg::OP_LOAD)
                    begin
                        state_next = S_LOAD1;
                    end
                    else if (op == spbc_pkg::OP_QUERY)
                    begin
                        state_next = S_QCHECK;
                    end
                    else if (op == spbc_pkg::OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD1:
            begin
                cmd.ld_wr1 = 1'b1;
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                cmd.ld_wr2 = 1'b1;
                state_next = S_IDLE;
            end
            S_QCHECK:
            begin
                cmd.idx_clear = 1'b1;
                state_next    = stat.q_ok ? S_INIT : S_BAD;
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.idx_clear  = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                // let the last compare land
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = stat.found ? S_SETTLE : S_FINAL;
            end
            S_SETTLE:
            begin
                cmd.settle_wr = 1'b1;
                cmd.idx_clear = 1'b1;
                state_next    = S_RELAX;
            end
            S_RELAX:
            begin
                cmd.relax_rd = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_RELAX_END;
                end
            end
            S_RELAX_END:
            begin
                // last relax write retires here
                cmd.idx_clear  = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_SCAN;
            end
            S_FINAL:
            begin
                cmd.fin_rd = 1'b1;
                state_next = S_FINAL_WAIT;
            end
            S_FINAL_WAIT:
            begin
                cmd.report = 1'b1;
                state_next = S_IDLE;
            end
            S_BAD:
            begin
                cmd.report_bad = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/spbc_datapath.sv
// Datapath of the shortest-path budget check unit: edge matrix memory,
// distance memory with settled flags, index counters, scan and relax logic.
// Depends on spbc_pkg.

module spbc_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  spbc_pkg::spbc_cmd_t           cmd,
    output spbc_pkg::spbc_stat_t          stat,
    input  logic                          cfg_wr,
    input  logic [spbc_pkg::CFG_W-1:0]    cfg_data,
    input  logic [spbc_pkg::NODE_W-1:0]   node_a,
    input  logic [spbc_pkg::NODE_W-1:0]   node_b,
    input  logic [spbc_pkg::WEIGHT_W-1:0] weight,
    input  logic [spbc_pkg::BUDGET_W-1:0] budget,
    output logic                          done,
    output logic                          status,
    output logic [spbc_pkg::BUDGET_W-1:0] leftover
);

    localparam int IDX_W  = spbc_pkg::IDX_W;
    localparam int EA_W   = spbc_pkg::EA_W;
    localparam int DB     = spbc_pkg::DIST_BITS;
    localparam int WB     = spbc_pkg::WEIGHT_BITS;
    localparam int NW     = spbc_pkg::NODE_W;
    localparam int BW     = spbc_pkg::BUDGET_W;
    localparam int SUM_W  = spbc_pkg::SUM_W;
    localparam int CMP_W  = spbc_pkg::CMP_W;
    localparam int EDGES  = 1 << EA_W;
    localparam int NODES  = spbc_pkg::MAX_NODES;

    // Memories: distance word carries the settled flag in its top bit
    logic [WB-1:0] edge_mem [EDGES];
    logic [DB:0]   dist_mem [NODES];

    logic [spbc_pkg::CFG_W-1:0] ncfg_reg;
    logic [NW-1:0]              a_reg;
    logic [NW-1:0]              b_reg;
    logic [WB-1:0]              w_reg;
    logic [BW-1:0]              budget_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [EA_W-1:0]            clr_addr_reg;
    logic [WB-1:0]              edge_q_reg;
    logic [DB:0]                dist_q_reg;
    logic                       rd_scan_reg;
    logic                       rd_relax_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic [IDX_W-1:0]           best_reg;
    logic [DB-1:0]              bestd_reg;
    logic                       found_reg;
    logic                       done_reg;
    logic                       status_reg;
    logic [BW-1:0]              leftover_reg;

    logic [IDX_W-1:0] cnt_m1;
    logic [31:0]      cnt_int;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic             ld_ok;
    logic             edge_we;
    logic [EA_W-1:0]  edge_waddr;
    logic [WB-1:0]    edge_wdata;
    logic             dist_we;
    logic [IDX_W-1:0] dist_waddr;
    logic [DB:0]      dist_wdata;
    logic [IDX_W-1:0] dist_raddr;
    logic [SUM_W-1:0] sum;
    logic [DB-1:0]    cand;
    logic             relax_hit;
    logic             scan_hit;
    logic [DB-1:0]    fin_d;
    logic             fin_ok;

    // Effective node count: zero acts as one, above the maximum clamps
    always_comb
    begin
        if (ncfg_reg == '0)
        begin
            cnt_int = 32'd1;
        end
        else if (32'(ncfg_reg) > NODES)
        begin
            cnt_int = NODES;
        end
        else
        begin
            cnt_int = 32'(ncfg_reg);
        end
        cnt_m1 = IDX_W'(cnt_int - 32'd1);
    end

    assign a_idx = IDX_W'(a_reg - NW'(1));
    assign b_idx = IDX_W'(b_reg - NW'(1));

    assign ld_ok = (a_reg != '0) && (32'(a_reg) <= NODES) &&
                   (b_reg != '0) && (32'(b_reg) <= NODES);

    assign stat.q_ok     = (a_reg != '0) && (32'(a_reg) <= cnt_int) &&
                           (b_reg != '0) && (32'(b_reg) <= cnt_int);
    assign stat.clr_last = (clr_addr_reg == {EA_W{1'b1}});
    assign stat.idx_last = (idx_reg == cnt_m1);
    assign stat.found    = found_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncfg_reg <= spbc_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            ncfg_reg <= cfg_data;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg      <= node_a;
            b_reg      <= node_b;
            w_reg      <= weight[WB-1:0];
            budget_reg <= budget;
        end
    end

    // Index and clear address counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.init_wr || cmd.scan_rd || cmd.relax_rd)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + EA_W'(1);
            end
        end
    end

    // Edge memory write select: clearing pass or one of the two mirrored writes
    always_comb
    begin
        edge_we    = 1'b0;
        edge_waddr = {a_idx, b_idx};
        edge_wdata = w_reg;
        if (cmd.clr_wr)
        begin
            edge_we    = 1'b1;
            edge_waddr = clr_addr_reg;
            edge_wdata = '0;
        end
        else if (cmd.ld_wr1)
        begin
            edge_we = ld_ok;
        end
        else if (cmd.ld_wr2)
        begin
            edge_we    = ld_ok;
            edge_waddr = {b_idx, a_idx};
        end
    end

    // Edge memory, registered read of the row of the node being settled
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_q_reg <= edge_mem[{best_reg, idx_reg}];
    end

    // Relax: saturating candidate through the settled node, plus the scan compare
    always_comb
    begin
        sum = SUM_W'(bestd_reg) + SUM_W'(edge_q_reg);
        if (sum > SUM_W'(spbc_pkg::DIST_INF))
        begin
            cand = spbc_pkg::DIST_INF;
        end
        else
        begin
            cand = sum[DB-1:0];
        end
        relax_hit = rd_relax_reg && (edge_q_reg != '0) && (cand < dist_q_reg[DB-1:0]);
        scan_hit  = rd_scan_reg && !dist_q_reg[DB] && (dist_q_reg[DB-1:0] < bestd_reg);
    end

    // Distance memory write and read select
    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = idx_reg;
        dist_wdata = {1'b0, (idx_reg == a_idx) ? {DB{1'b0}} : spbc_pkg::DIST_INF};
        if (cmd.init_wr)
        begin
            dist_we = 1'b1;
        end
        else if (cmd.settle_wr)
        begin
            dist_we    = 1'b1;
            dist_waddr = best_reg;
            dist_wdata = {1'b1, bestd_reg};
        end
        else if (relax_hit)
        begin
            dist_we    = 1'b1;
            dist_waddr = rd_idx_reg;
            dist_wdata = {dist_q_reg[DB], cand};
        end
        dist_raddr = cmd.fin_rd ? b_idx : idx_reg;
    end

    // Distance memory with registered read
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_q_reg <= dist_mem[dist_raddr];
    end

    // Read pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_scan_reg  <= 1'b0;
            rd_relax_reg <= 1'b0;
        end
        else
        begin
            rd_scan_reg  <= cmd.scan_rd;
            rd_relax_reg <= cmd.relax_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
    end

    // Minimum scan: strict compare keeps the lowest-numbered node on a tie
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            found_reg <= 1'b0;
        end
        else if (scan_hit)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_clear)
        begin
            bestd_reg <= spbc_pkg::DIST_INF;
        end
        else if (scan_hit)
        begin
            bestd_reg <= dist_q_reg[DB-1:0];
            best_reg  <= rd_idx_reg;
        end
    end

    // Final budget check
    assign fin_d  = dist_q_reg[DB-1:0];
    assign fin_ok = (fin_d != spbc_pkg::DIST_INF) && (CMP_W'(fin_d) <= CMP_W'(budget_reg));

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report || cmd.report_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report && fin_ok)
        begin
            status_reg   <= 1'b0;
            leftover_reg <= BW'(CMP_W'(budget_reg) - CMP_W'(fin_d));
        end
        else if (cmd.report || cmd.report_bad)
        begin
            status_reg   <= 1'b1;
            leftover_reg <= '0;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign leftover = leftover_reg;

endmodule

### test/tb_shortest_path_budget_check_unit.sv
// Self-checking testbench for shortest_path_budget_check_unit: a directed command table,
// then random graph-building and query phases across several node_count settings.
// Depends on spbc_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_shortest_path_budget_check_unit;

    localparam int OP_W        = spbc_pkg::OP_W;
    localparam int NODE_W      = spbc_pkg::NODE_W;
    localparam int WEIGHT_W    = spbc_pkg::WEIGHT_W;
    localparam int BUDGET_W    = spbc_pkg::BUDGET_W;
    localparam int CFG_W       = spbc_pkg::CFG_W;
    localparam int MAX_NODES   = spbc_pkg::MAX_NODES;
    localparam int WEIGHT_BITS = spbc_pkg::WEIGHT_BITS;
    localparam int DIST_BITS   = spbc_pkg::DIST_BITS;

    localparam logic [DIST_BITS-1:0] DIST_INF         = spbc_pkg::DIST_INF;
    localparam logic [CFG_W-1:0]     NODE_COUNT_RESET = spbc_pkg::NODE_COUNT_RESET;
    localparam logic [OP_W-1:0]      OP_LOAD          = spbc_pkg::OP_LOAD;
    localparam logic [OP_W-1:0]      OP_QUERY         = spbc_pkg::OP_QUERY;
    localparam logic [OP_W-1:0]      OP_CLEAR         = spbc_pkg::OP_CLEAR;

    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam logic            ST_OK       = 1'b0;
    localparam logic            ST_FAIL     = 1'b1;
    localparam int              CYCLE_LIMIT = 5000000;
    // Longest silent operation is the matrix sweep of a clear
    localparam int              QUIET_CYCLES = 4200;

    typedef struct packed {
        logic                status;
        logic [BUDGET_W-1:0] leftover;
    } answer_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
        logic [WEIGHT_W-1:0] w;
        logic [BUDGET_W-1:0] bud;
        logic                typed;
        answer_t             ans;
    } cmd_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     op = '0;
    logic [NODE_W-1:0]   node_a = '0;
    logic [NODE_W-1:0]   node_b = '0;
    logic [WEIGHT_W-1:0] weight = '0;
    logic [BUDGET_W-1:0] budget = '0;
    logic                done;
    logic                status;
    logic [BUDGET_W-1:0] leftover;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;

    // Mirror of the unit's graph and node_count register
    logic [WEIGHT_BITS-1:0] edge_cost [MAX_NODES][MAX_NODES];
    logic [CFG_W-1:0]       node_count_model;

    answer_t pending_answers [$];
    answer_t got_answer;
    cmd_t    directed_cmds [$];
    bit      steady;
    int      cycle_cnt;
    int      n_items;
    int      n_queries;
    int      n_checked;
    int      n_errors;
    int      n_settings;
    int      idx;

    shortest_path_budget_check_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .node_a    (node_a),
        .node_b    (node_b),
        .weight    (weight),
        .budget    (budget),
        .done      (done),
        .status    (status),
        .leftover  (leftover),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Zero the mirrored adjacency matrix
    function automatic void wipe_graph();
        for (int i = 0; i < MAX_NODES; i++)
            for (int j = 0; j < MAX_NODES; j++)
                edge_cost[i][j] = '0;
    endfunction

    // Clamp the node_count register to the usable node range
    function automatic int active_count();
        if (node_count_model == 0)
            return 1;
        if (node_count_model > MAX_NODES)
            return MAX_NODES;
        return int'(node_count_model);
    endfunction

    // Dijkstra over the first cnt nodes, zero-based src and dst, saturating sums
    function automatic logic [DIST_BITS-1:0] path_cost(int src, int dst, int cnt);
        logic [DIST_BITS-1:0] tent_dist [MAX_NODES];
        bit                   seen [MAX_NODES];
        int                   best;
        logic [DIST_BITS-1:0] bestd;
        bit                   found;
        logic [DIST_BITS:0]   cand;
        for (int i = 0; i < cnt; i++)
        begin
            tent_dist[i] = DIST_INF;
            seen[i]      = 1'b0;
        end
        tent_dist[src] = '0;
        for (int k = 0; k < cnt; k++)
        begin
            best  = 0;
            bestd = DIST_INF;
            found = 1'b0;
            // lowest-numbered node wins a tie
            for (int i = 0; i < cnt; i++)
            begin
                if (!seen[i] && tent_dist[i] < bestd)
                begin
                    best  = i;
                    bestd = tent_dist[i];
                    found = 1'b1;
                end
            end
            if (!found)
                break;
            seen[best] = 1'b1;
            for (int v = 0; v < cnt; v++)
            begin
                if (edge_cost[best][v] != 0)
                begin
                    cand = {1'b0, bestd} + (DIST_BITS + 1)'(edge_cost[best][v]);
                    if (cand > {1'b0, DIST_INF})
                        cand = {1'b0, DIST_INF};
                    if (cand[DIST_BITS-1:0] < tent_dist[v])
                        tent_dist[v] = cand[DIST_BITS-1:0];
                end
            end
        end
        return tent_dist[dst];
    endfunction

    // Work out the status and leftover budget of one query
    function automatic answer_t judge_query(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                            logic [BUDGET_W-1:0] bud);
        answer_t              r;
        int                   cnt;
        logic [DIST_BITS-1:0] d;
        cnt        = active_count();
        r.status   = ST_FAIL;
        r.leftover = '0;
        if (a >= 1 && a <= cnt && b >= 1 && b <= cnt)
        begin
            d = path_cost(int'(a) - 1, int'(b) - 1, cnt);
            if (d != DIST_INF && d <= bud)
            begin
                r.status   = ST_OK;
                r.leftover = bud - d;
            end
        end
        return r;
    endfunction

    function automatic void add_row(logic [OP_W-1:0] o, int a, int b, int w, int bud,
                                    bit typed, logic st, int lo);
        cmd_t c;
        c.op           = o;
        c.a            = NODE_W'(a);
        c.b            = NODE_W'(b);
        c.w            = WEIGHT_W'(w);
        c.bud          = BUDGET_W'(bud);
        c.typed        = typed;
        c.ans.status   = st;
        c.ans.leftover = BUDGET_W'(lo);
        directed_cmds.push_back(c);
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int rand_gap();
        int p;
        if (steady)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Mostly nodes in use, some beyond node_count, a few out of range
    function automatic logic [NODE_W-1:0] rand_node(int cnt, int in_use_pct);
        int p;
        p = $urandom_range(0, 99);
        if (p < in_use_pct)
            return NODE_W'($urandom_range(1, cnt));
        if (p < in_use_pct + 6)
            return NODE_W'($urandom_range(1, MAX_NODES));
        if (p < in_use_pct + 9)
            return '0;
        return NODE_W'($urandom_range(MAX_NODES + 1, 127));
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return WEIGHT_W'($urandom_range(1, 20));
        if (p < 80)
            return '0;
        if (p < 90)
            return WEIGHT_W'($urandom);
        return WEIGHT_W'($urandom_range(65000, 65535));
    endfunction

    // Drop start and hold until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_answers.size() != 0);
    endtask

    // Drive one command transaction and update the mirror when it is taken
    task automatic issue_cmd(cmd_t c);
        int gap;
        gap = rand_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        op     <= c.op;
        node_a <= c.a;
        node_b <= c.b;
        weight <= c.w;
        budget <= c.bud;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c.op != OP_UNUSED)
            n_items++;
        case (c.op)
            OP_LOAD:
            begin
                if (c.a >= 1 && c.a <= MAX_NODES && c.b >= 1 && c.b <= MAX_NODES)
                begin
                    edge_cost[c.a - 1][c.b - 1] = c.w;
                    edge_cost[c.b - 1][c.a - 1] = c.w;
                end
            end
            OP_CLEAR:
                wipe_graph();
            OP_QUERY:
            begin
                n_queries++;
                pending_answers.push_back(c.typed ? c.ans : judge_query(c.a, c.b, c.bud));
            end
            default:
                ;
        endcase
    endtask

    // Write node_count once the unit has gone quiet
    task automatic set_node_count(logic [CFG_W-1:0] val);
        drain();
        repeat (QUIET_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        node_count_model = val;
        n_settings++;
        cfg_valid <= 1'b0;
    endtask

    // Build random graphs and query them under one node_count setting
    task automatic random_phase(logic [CFG_W-1:0] cfg_val, int n_cmds, bit steady_run);
        int                   cnt;
        int                   made;
        int                   kind;
        longint               near;
        logic [DIST_BITS-1:0] d;
        cmd_t                 c;
        set_node_count(cfg_val);
        steady = steady_run;
        cnt    = active_count();
        made   = 0;
        while (made < n_cmds)
        begin
            kind    = $urandom_range(0, 99);
            c.op    = OP_UNUSED;
            c.a     = NODE_W'($urandom);
            c.b     = NODE_W'($urandom);
            c.w     = WEIGHT_W'($urandom);
            c.bud   = BUDGET_W'($urandom);
            c.typed = 1'b0;
            c.ans   = '0;
            if (kind < 45)
            begin
                c.op = OP_LOAD;
                c.a  = rand_node(cnt, 85);
                c.b  = rand_node(cnt, 85);
                c.w  = rand_weight();
            end
            else if (kind < 88)
            begin
                c.op = OP_QUERY;
                c.a  = rand_node(cnt, 88);
                c.b  = rand_node(cnt, 88);
                // aim about half the budgets within two of the shortest distance
                if ($urandom_range(0, 1) && c.a >= 1 && c.a <= cnt && c.b >= 1 && c.b <= cnt)
                begin
                    d = path_cost(int'(c.a) - 1, int'(c.b) - 1, cnt);
                    if (d != DIST_INF)
                    begin
                        near = longint'(d) + longint'($urandom_range(0, 4)) - 2;
                        if (near < 0)
                            near = 0;
                        if (near > 24'hFFFFFF)
                            near = 24'hFFFFFF;
                        c.bud = BUDGET_W'(near);
                    end
                end
                else if ($urandom_range(0, 9) == 0)
                    c.bud = '0;
            end
            else if (kind < 92)
                c.op = OP_CLEAR;
            if (kind >= 97 && !steady)
                drain();
            else
            begin
                issue_cmd(c);
                if (c.op != OP_UNUSED)
                    made++;
            end
        end
        steady = 1'b0;
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual status %0d leftover %0d",
                         $time, status, leftover);
                n_errors++;
            end
            else
            begin
                got_answer = pending_answers.pop_front();
                n_checked++;
                if (status !== got_answer.status)
                begin
                    $display("%0t ns: status mismatch, expected %0d, actual %0d",
                             $time, got_answer.status, status);
                    n_errors++;
                end
                if (leftover !== got_answer.leftover)
                begin
                    $display("%0t ns: leftover mismatch, expected %0d, actual %0d",
                             $time, got_answer.leftover, leftover);
                    n_errors++;
                end
            end
        end
    end

    // End the run if it hangs
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_cnt, pending_answers.size());
        $display("shortest_path_budget_check_unit regression: fail");
        $finish;
    end

    initial
    begin
        wipe_graph();
        node_count_model = NODE_COUNT_RESET;
        steady     = 1'b0;
        n_items    = 0;
        n_queries  = 0;
        n_checked  = 0;
        n_errors   = 0;
        n_settings = 0;

        // Directed table, node_count at its reset value of 64
        add_row(OP_QUERY, 1, 1, 0, 0, 1, ST_OK, 0);
        add_row(OP_QUERY, 1, 2, 0, 24'hFFFFFF, 1, ST_FAIL, 0);
        add_row(OP_QUERY, 0, 1, 0, 100, 1, ST_FAIL, 0);
        add_row(OP_QUERY, 127, 127, 16'hFFFF, 24'hFFFFFF, 1, ST_FAIL, 0);
        add_row(OP_LOAD, 1, 2, 16'hFFFF, 0, 0, ST_OK, 0);
        add_row(OP_QUERY, 1, 2, 0, 65535, 1, ST_OK, 0);
        add_row(OP_QUERY, 1, 2, 0, 65534, 1, ST_FAIL, 0);
        add_row(OP_QUERY, 2, 1, 0, 24'hFFFFFF, 1, ST_OK, 24'hFF0000);
        // self edge never shortens anything
        add_row(OP_LOAD, 3, 3, 1, 0, 0, ST_OK, 0);
        add_row(OP_QUERY, 3, 3, 0, 5, 1, ST_OK, 5);
        // loads with an endpoint out of range are dropped
        add_row(OP_LOAD, 0, 5, 7, 0, 0, ST_OK, 0);
        add_row(OP_LOAD, 5, 65, 7, 0, 0, ST_OK, 0);
        add_row(OP_LOAD, 127, 1, 7, 0, 0, ST_OK, 0);
        add_row(OP_QUERY, 1, 5, 0, 100, 0, ST_OK, 0);
        add_row(OP_LOAD, 64, 63, 1, 0, 0, ST_OK, 0);
        add_row(OP_QUERY, 64, 63, 0, 10, 1, ST_OK, 9);
        add_row(OP_UNUSED, 127, 127, 16'hFFFF, 24'hFFFFFF, 0, ST_OK, 0);
        // zero weight removes the edge
        add_row(OP_LOAD, 1, 2, 0, 0, 0, ST_OK, 0);
        add_row(OP_QUERY, 1, 2, 0, 100, 1, ST_FAIL, 0);
        // two equal-cost routes meet at node 6
        add_row(OP_LOAD, 1, 4, 2, 0, 0, ST_OK, 0);
        add_row(OP_LOAD, 1, 5, 2, 0, 0, ST_OK, 0);
        add_row(OP_LOAD, 4, 6, 1, 0, 0, ST_OK, 0);
        add_row(OP_LOAD, 5, 6, 1, 0, 0, ST_OK, 0);
        add_row(OP_QUERY, 1, 6, 0, 3, 0, ST_OK, 0);
        add_row(OP_CLEAR, 0, 0, 0, 0, 0, ST_OK, 0);
        add_row(OP_QUERY, 64, 63, 0, 10, 1, ST_FAIL, 0);

        // Hold reset, then let the power-up sweep run under busy
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < directed_cmds.size(); idx++)
            issue_cmd(directed_cmds[idx]);

        random_phase(7'd5, 14, 1'b0);
        random_phase(7'd0, 5, 1'b0);
        random_phase(7'd127, 6, 1'b0);
        random_phase(7'd1, 5, 1'b0);
        random_phase(7'd12, 18, 1'b1);
        random_phase(7'd64, 6, 1'b0);
        random_phase(7'd3, 10, 1'b0);
        random_phase(CFG_W'($urandom_range(2, 16)), 12, 1'b0);

        // Wait out the last results and any trailing sweep
        drain();
        repeat (QUIET_CYCLES) @(posedge clk);

        $display("covered %0d commands, %0d queries, %0d results checked, %0d node_count writes",
                 n_items, n_queries, n_checked, n_settings);
        $display("node_count settings included 0, 1 and 127 plus small and full graphs");
        if (n_errors == 0 && pending_answers.size() == 0)
            $display("shortest_path_budget_check_unit regression: pass");
        else
            $display("shortest_path_budget_check_unit regression: fail");
        $finish;
    end

endmodule
